FILE: hw/rtl/ecfb_pkg.sv
`default_nettype none

package ecfb_pkg;

    // Item modes carried on the input channel.
    typedef enum logic [2:0] {
        MODE_DRIVE_STEP  = 3'd0,
        MODE_SERVO_STEP  = 3'd1,
        MODE_SEND_TICK   = 3'd2,
        MODE_DRIVE_RESET = 3'd3,
        MODE_SERVO_RESET = 3'd4
    } mode_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYNC_BYTE        = 3'd0;
    localparam logic [2:0] CFG_DRIVE_LIMIT      = 3'd1;
    localparam logic [2:0] CFG_DRIVE_CENTER     = 3'd2;
    localparam logic [2:0] CFG_DRIVE_UPPER_DEAD = 3'd3;
    localparam logic [2:0] CFG_DRIVE_LOWER_DEAD = 3'd4;
    localparam logic [2:0] CFG_SERVO_LIMIT      = 3'd5;
    localparam logic [2:0] CFG_SERVO_CENTER     = 3'd6;

    // Frame slots.
    localparam logic [1:0] SLOT_SYNC  = 2'd0;
    localparam logic [1:0] SLOT_DRIVE = 2'd1;
    localparam logic [1:0] SLOT_SERVO = 2'd2;
    localparam logic [1:0] SLOT_PINS  = 2'd3;

    // Reset values of the registers and counters.
    localparam logic [7:0] SYNC_BYTE_RST        = 8'd240;
    localparam logic [5:0] DRIVE_LIMIT_RST      = 6'd32;
    localparam logic [5:0] DRIVE_CENTER_RST     = 6'd16;
    localparam logic [5:0] DRIVE_UPPER_DEAD_RST = 6'd17;
    localparam logic [5:0] DRIVE_LOWER_DEAD_RST = 6'd15;
    localparam logic [6:0] SERVO_LIMIT_RST      = 7'd18;
    localparam logic [6:0] SERVO_CENTER_RST     = 7'd9;

    // Drive byte direction bits and magnitude ceiling.
    localparam logic [7:0] DRIVE_FWD_BIT = 8'h80;
    localparam logic [7:0] DRIVE_REV_BIT = 8'h40;
    localparam logic [5:0] DRIVE_MAG_MAX = 6'd63;

    // Live configuration.
    typedef struct packed {
        logic [7:0] sync_byte;
        logic [5:0] drive_limit;
        logic [5:0] drive_center;
        logic [5:0] drive_upper_dead;
        logic [5:0] drive_lower_dead;
        logic [6:0] servo_limit;
        logic [6:0] servo_center;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] frame_slot;
        logic       drive_at_min;
        logic       drive_at_max;
        logic       servo_at_min;
        logic       servo_at_max;
    } result_t;

    // Magnitude times four, saturated at the ceiling.
    function automatic logic [5:0] clamp_mag(input logic [5:0] diff);
        logic [5:0] mag;
        begin
            if (diff[5:4] != 2'b00) begin
                mag = DRIVE_MAG_MAX;
            end else begin
                mag = {diff[3:0], 2'b00};
            end
            return mag;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/encoder_command_frame_builder_unit.sv
// Flow: a request accepted into the input register moves into the result register
// once that register has room, and m_valid rises when the result is loaded.
// Throughput: one request per cycle while m_ready is high; the input register and the result
// register each accept while the next stage drains in the same cycle.
// Reset: synchronous active-low aresetn restores the registers, the drive and
// servo counters to their centers, the frame slot to the sync byte, and empties both stages.
`default_nettype none

module encoder_command_frame_builder_unit
    import ecfb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_mode,
    input  wire logic       s_step_down,
    input  wire logic [7:0] s_switch_pins,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_byte,
    output logic [1:0]      m_frame_slot,
    output logic            m_drive_at_min,
    output logic            m_drive_at_max,
    output logic            m_servo_at_min,
    output logic            m_servo_at_max
);

    cfg_t    cfg;
    result_t result;
    result_t m_result;
    logic    out_load;
    logic    out_free;

    ecfb_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    ecfb_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_step_down   (s_step_down),
        .s_switch_pins (s_switch_pins),
        .out_free      (out_free),
        .out_load      (out_load),
        .result        (result)
    );

    ecfb_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .out_load (out_load),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // Break the result out onto its field ports.
    assign m_tx_valid     = m_result.tx_valid;
    assign m_tx_byte      = m_result.tx_byte;
    assign m_frame_slot   = m_result.frame_slot;
    assign m_drive_at_min = m_result.drive_at_min;
    assign m_drive_at_max = m_result.drive_at_max;
    assign m_servo_at_min = m_result.servo_at_min;
    assign m_servo_at_max = m_result.servo_at_max;

endmodule

`default_nettype wire

FILE: hw/rtl/ecfb_cfg_regs.sv
`default_nettype none

module ecfb_cfg_regs
    import ecfb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wr_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write and update one field.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:        cfg_next.sync_byte        = cfg_wr_data;
                CFG_DRIVE_LIMIT:      cfg_next.drive_limit      = cfg_wr_data[5:0];
                CFG_DRIVE_CENTER:     cfg_next.drive_center     = cfg_wr_data[5:0];
                CFG_DRIVE_UPPER_DEAD: cfg_next.drive_upper_dead = cfg_wr_data[5:0];
                CFG_DRIVE_LOWER_DEAD: cfg_next.drive_lower_dead = cfg_wr_data[5:0];
                CFG_SERVO_LIMIT:      cfg_next.servo_limit      = cfg_wr_data[6:0];
                CFG_SERVO_CENTER:     cfg_next.servo_center     = cfg_wr_data[6:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte        <= SYNC_BYTE_RST;
            cfg_reg.drive_limit      <= DRIVE_LIMIT_RST;
            cfg_reg.drive_center     <= DRIVE_CENTER_RST;
            cfg_reg.drive_upper_dead <= DRIVE_UPPER_DEAD_RST;
            cfg_reg.drive_lower_dead <= DRIVE_LOWER_DEAD_RST;
            cfg_reg.servo_limit      <= SERVO_LIMIT_RST;
            cfg_reg.servo_center     <= SERVO_CENTER_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ecfb_core.sv
`default_nettype none

module ecfb_core
    import ecfb_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_mode,
    input  wire logic       s_step_down,
    input  wire logic [7:0] s_switch_pins,
    input  wire logic       out_free,
    output logic            out_load,
    output result_t         result
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [2:0] mode_reg;
    logic       step_down_reg;
    logic [7:0] pins_reg;

    logic [5:0] drive_count_reg;
    logic [5:0] drive_count_next;
    logic [6:0] servo_count_reg;
    logic [6:0] servo_count_next;
    logic [1:0] slot_index_reg;
    logic [1:0] slot_index_next;

    logic [7:0] drive_byte;
    logic [7:0] tx_byte;
    logic       tx_valid;

    // The held request moves on whenever the result register has room.
    assign out_load = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end else if (out_load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Input payload register; loaded on every accepted request.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg      <= s_mode;
            step_down_reg <= s_step_down;
            pins_reg      <= s_switch_pins;
        end
    end

    // Drive byte from the current drive count, sign-magnitude.
    always_comb begin
        if (drive_count_reg > cfg.drive_upper_dead) begin
            drive_byte = DRIVE_FWD_BIT
                | {2'b00, clamp_mag(drive_count_reg - cfg.drive_upper_dead)};
        end else if (drive_count_reg < cfg.drive_lower_dead) begin
            drive_byte = DRIVE_REV_BIT
                | {2'b00, clamp_mag(cfg.drive_lower_dead - drive_count_reg)};
        end else begin
            drive_byte = 8'h00;
        end
    end

    // Counter updates and frame byte selection for the held request.
    always_comb begin
        drive_count_next = drive_count_reg;
        servo_count_next = servo_count_reg;
        slot_index_next  = slot_index_reg;
        tx_valid         = 1'b0;
        tx_byte          = 8'h00;
        if (out_load) begin
            unique case (mode_t'(mode_reg))
                MODE_DRIVE_STEP: begin
                    if (step_down_reg) begin
                        if (drive_count_reg != 6'd0) begin
                            drive_count_next = drive_count_reg - 6'd1;
                        end
                    end else if (drive_count_reg < cfg.drive_limit) begin
                        drive_count_next = drive_count_reg + 6'd1;
                    end
                end
                MODE_SERVO_STEP: begin
                    if (step_down_reg) begin
                        if (servo_count_reg != 7'd0) begin
                            servo_count_next = servo_count_reg - 7'd1;
                        end
                    end else if (servo_count_reg < cfg.servo_limit) begin
                        servo_count_next = servo_count_reg + 7'd1;
                    end
                end
                MODE_SEND_TICK: begin
                    tx_valid        = 1'b1;
                    slot_index_next = slot_index_reg + 2'd1;
                    unique case (slot_index_reg)
                        SLOT_SYNC:  tx_byte = cfg.sync_byte;
                        SLOT_DRIVE: tx_byte = drive_byte;
                        SLOT_SERVO: tx_byte = {1'b0, servo_count_reg};
                        SLOT_PINS:  tx_byte = ~pins_reg;
                        default:    tx_byte = 8'h00;
                    endcase
                end
                MODE_DRIVE_RESET: drive_count_next = cfg.drive_center;
                MODE_SERVO_RESET: servo_count_next = cfg.servo_center;
                default: begin
                    // Unused modes leave all state alone.
                    drive_count_next = drive_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_count_reg <= DRIVE_CENTER_RST;
            servo_count_reg <= SERVO_CENTER_RST;
            slot_index_reg  <= SLOT_SYNC;
        end else begin
            drive_count_reg <= drive_count_next;
            servo_count_reg <= servo_count_next;
            slot_index_reg  <= slot_index_next;
        end
    end

    // Result fields; flags reflect the counters after this request.
    always_comb begin
        result.tx_valid     = tx_valid;
        result.tx_byte      = tx_byte;
        result.frame_slot   = tx_valid ? slot_index_reg : SLOT_SYNC;
        result.drive_at_min = (drive_count_next == 6'd0);
        result.drive_at_max = (drive_count_next == cfg.drive_limit);
        result.servo_at_min = (servo_count_next == 7'd0);
        result.servo_at_max = (servo_count_next == cfg.servo_limit);
    end

`ifndef SYNTHESIS
    // The slot moves only on a send tick.
    a_slot_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && mode_reg != MODE_SEND_TICK) |=> $stable(slot_index_reg))
        else $error("frame slot moved without a send tick");

    // A send tick advances the slot by one.
    a_slot_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && mode_reg == MODE_SEND_TICK)
        |=> slot_index_reg == $past(slot_index_reg) + 2'd1)
        else $error("frame slot did not advance on a send tick");

    // Counters change only when a request is processed.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_load |=> ($stable(drive_count_reg) && $stable(servo_count_reg)))
        else $error("counter changed without a request");

    // A held request is not dropped while the result side is stalled.
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(mode_reg)))
        else $error("held request lost during stall");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/ecfb_out_reg.sv
`default_nettype none

module ecfb_out_reg
    import ecfb_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    out_load,
    input  wire result_t result,
    output logic         out_free,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Room for a new result when empty or when the current one leaves now.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (out_load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            data_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

`ifndef SYNTHESIS
    // A result is only loaded when there is room for it.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded over an unaccepted result");

    // A stalled result keeps its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !m_ready) |=> (valid_reg && $stable(data_reg)))
        else $error("stalled result changed");

    // An empty register with no load stays empty.
    a_empty_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!valid_reg && !out_load) |=> !valid_reg)
        else $error("result appeared without a load");
`endif

endmodule

`default_nettype wire
